@@ rtl/idps_pkg.sv @@
// Shared types, constants and helper functions for the diff/posterize/sharpen block.
package idps_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DEF_DIM        = 128;

  // command codes (in_tuser)
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  // posterize thresholds and output levels
  localparam logic [7:0] THR_LOW  = 8'd32;
  localparam logic [7:0] THR_HIGH = 8'd96;
  localparam logic [7:0] VAL_ZERO = 8'd0;
  localparam logic [7:0] VAL_MID  = 8'd128;
  localparam logic [7:0] VAL_FULL = 8'd255;

  typedef logic [1:0] lvl_t;
  localparam lvl_t LVL_ZERO = 2'd0;
  localparam lvl_t LVL_MID  = 2'd1;
  localparam lvl_t LVL_FULL = 2'd2;

  // per-item control handed from the counter logic to the filter stage
  typedef struct packed {
    logic wr;      // pixel pair stored into the line buffers
    logic emit;    // item produces a result
    logic last;    // result closes the frame
    logic border;  // result lies on the frame border
    lvl_t level;   // posterized level of the incoming pair
  } ctl_t;

  function automatic lvl_t posterize(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    if (d < THR_LOW) begin
      return LVL_ZERO;
    end else if (d < THR_HIGH) begin
      return LVL_MID;
    end
    return LVL_FULL;
  endfunction

  function automatic logic [7:0] lvl_value(input lvl_t l);
    logic [7:0] v;
    case (l)
      LVL_ZERO: v = VAL_ZERO;
      LVL_MID:  v = VAL_MID;
      default:  v = VAL_FULL;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/image_diff_posterize_sharpen_top.sv @@
// Top level of the absolute-difference posterize and cross sharpen stream block.
//
// Input channel (in_*): one item per pixel pair, in raster order. in_tuser is the
// command: pixel pair, or drain one pending result. Pixel pairs of a row other than
// the first each release the result one row back; once the whole frame is in,
// drain items flush the last row. out_tlast marks the final pixel of a frame, after
// which the next pixel pair starts a new frame.
// Config channel (cfg_*): index 0 = width, 1 = height; any such write restarts the
// frame. Writes are always taken (cfg_ready high) and belong to idle periods.
// Throughput: one item per clock while the receiver keeps up. Each item passes one
// stage register (line buffer read, window and sharpen) and then the output
// register before its result shows on out_*.
// Line buffers are three MAX_WIDTH x 2-bit RAMs indexed by column, each with one
// read port; the read is issued on the accepting edge.
// Reset clears counters, handshake state and sets width/height to 128 (clamped to
// MAX_WIDTH/MAX_HEIGHT); line buffer contents are not cleared and need no sweep.
// Receiver stall: the output register holds its item, the stage register still
// takes one more item, then in_tready drops until out_tready returns.
module image_diff_posterize_sharpen_top import idps_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] pixel_a, [15:8] pixel_b
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] pixel_out
  output logic        out_tlast,  // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  ctl_t          ctl;
  logic [CW-1:0] col;
  logic          accept;
  logic          s_ready;

  assign cfg_ready = 1'b1;
  assign in_tready = s_ready;
  assign accept    = in_tvalid && s_ready;

  // counters and per-item decisions
  idps_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .accept(accept), .cmd(in_tuser),
    .pix_a(in_tdata[7:0]), .pix_b(in_tdata[15:8]),
    .ctl(ctl), .col(col)
  );

  // line buffers, sharpen and result register
  idps_filter #(.MAX_WIDTH(MAX_WIDTH)) u_filter (
    .clk(clk), .rst_n(rst_n),
    .accept(accept), .ctl(ctl), .col(col),
    .s_ready(s_ready),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_pix(out_tdata), .out_last(out_tlast)
  );

endmodule

@@ rtl/idps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module idps_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/idps_ctrl.sv @@
// Frame geometry registers, input/output position counters and per-item decisions.
module idps_ctrl import idps_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          accept,
  input  logic          cmd,
  input  logic [7:0]    pix_a,
  input  logic [7:0]    pix_b,
  output ctl_t          ctl,
  output logic [CW-1:0] col
);

  localparam int WDW  = (CW + 1 > 8) ? CW + 1 : 8;
  localparam int HDW  = (RW + 1 > 8) ? RW + 1 : 8;
  localparam int WRST = (DEF_DIM > MAX_WIDTH) ? MAX_WIDTH - 1 : DEF_DIM - 1;
  localparam int HRST = (DEF_DIM > MAX_HEIGHT) ? MAX_HEIGHT - 1 : DEF_DIM - 1;

  logic [CW-1:0] wm1_r, wm1_nxt, ic_r, ic_nxt, oc_r, oc_nxt;
  logic [RW-1:0] hm1_r, hm1_nxt, ir_r, ir_nxt, or_r, or_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] wm1_cfg;
  logic [RW-1:0] hm1_cfg;
  logic          pix;

  // clamped dimension minus one, stored ready for compares
  always_comb begin
    if (cfg_data == 8'd0) begin
      wm1_cfg = '0;
    end else if (WDW'(cfg_data) > WDW'(MAX_WIDTH)) begin
      wm1_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      wm1_cfg = CW'(cfg_data - 8'd1);
    end
    if (cfg_data == 8'd0) begin
      hm1_cfg = '0;
    end else if (HDW'(cfg_data) > HDW'(MAX_HEIGHT)) begin
      hm1_cfg = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1_cfg = RW'(cfg_data - 8'd1);
    end
  end

  assign pix = (cmd == CMD_PIXEL);

  always_comb begin
    ctl.wr     = pix && !done_r;
    ctl.emit   = pix ? (!done_r && (ir_r != '0)) : done_r;
    ctl.last   = (or_r == hm1_r) && (oc_r == wm1_r);
    ctl.border = (or_r == '0) || (or_r == hm1_r) || (oc_r == '0) || (oc_r == wm1_r);
    ctl.level  = posterize(pix_a, pix_b);
    col        = pix ? ic_r : oc_r;
  end

  always_comb begin
    wm1_nxt  = wm1_r;
    hm1_nxt  = hm1_r;
    ic_nxt   = ic_r;
    ir_nxt   = ir_r;
    oc_nxt   = oc_r;
    or_nxt   = or_r;
    done_nxt = done_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  wm1_nxt = wm1_cfg;
        REG_HEIGHT: hm1_nxt = hm1_cfg;
        default: ;
      endcase
      if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
        ic_nxt   = '0;
        ir_nxt   = '0;
        oc_nxt   = '0;
        or_nxt   = '0;
        done_nxt = 1'b0;
      end
    end else if (accept) begin
      if (ctl.wr) begin
        if (ic_r == wm1_r) begin
          ic_nxt = '0;
          if (ir_r == hm1_r) begin
            ir_nxt   = '0;
            done_nxt = 1'b1;
          end else begin
            ir_nxt = ir_r + 1'b1;
          end
        end else begin
          ic_nxt = ic_r + 1'b1;
        end
      end
      if (ctl.emit) begin
        if (ctl.last) begin
          ic_nxt   = '0;
          ir_nxt   = '0;
          oc_nxt   = '0;
          or_nxt   = '0;
          done_nxt = 1'b0;
        end else if (oc_r == wm1_r) begin
          oc_nxt = '0;
          or_nxt = or_r + 1'b1;
        end else begin
          oc_nxt = oc_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r  <= CW'(WRST);
      hm1_r  <= RW'(HRST);
      ic_r   <= '0;
      ir_r   <= '0;
      oc_r   <= '0;
      or_r   <= '0;
      done_r <= 1'b0;
    end else begin
      wm1_r  <= wm1_nxt;
      hm1_r  <= hm1_nxt;
      ic_r   <= ic_nxt;
      ir_r   <= ir_nxt;
      oc_r   <= oc_nxt;
      or_r   <= or_nxt;
      done_r <= done_nxt;
    end
  end

`ifndef SYNTH
  a_done_home: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (ic_r == '0 && ir_r == '0))
    else $error("input counters not parked after frame input");
  a_cols_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ic_r <= wm1_r) && (oc_r <= wm1_r) && (ir_r <= hm1_r) && (or_r <= hm1_r))
    else $error("position counter beyond frame size");
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_valid && ctl.emit && ctl.last) |=> (oc_r == '0 && or_r == '0 && !done_r))
    else $error("frame end did not restart counters");
`endif

endmodule

@@ rtl/idps_filter.sv @@
// Line buffers, 3x3 cross window and sharpen, with the stage and result registers.
module idps_filter import idps_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  ctl_t          ctl,
  input  logic [CW-1:0] col,
  output logic          s_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_pix,
  output logic          out_last
);

  logic          s1_valid_r, s1_valid_nxt;
  ctl_t          s1_ctl_r;
  logic [CW-1:0] s1_col_r;
  logic          fwd_r, fwd_nxt;
  lvl_t          prev_lvl_r, prev_ctr_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_pix_r;
  logic          out_last_r;
  logic          out_free, s1_adv, wr_en;
  logic [CW-1:0] raddr_b;
  lvl_t          rd_c, rd_r, rd_t;
  lvl_t          ctr_eff, top_eff;
  logic [7:0]    v_c, v_t, v_b, v_l, v_r, res;
  logic signed [11:0] acc;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign s_ready  = !s1_valid_r || out_free;
  assign wr_en    = s1_adv && s1_ctl_r.wr;
  assign raddr_b  = (col == CW'(MAX_WIDTH - 1)) ? '0 : col + 1'b1;

  // previous row (center, and a copy for the right neighbor) and the row above it
  idps_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_ram_ctr (
    .clk(clk), .we(wr_en), .waddr(s1_col_r), .wdata(s1_ctl_r.level),
    .re(accept), .raddr(col), .rdata(rd_c)
  );
  idps_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_ram_rgt (
    .clk(clk), .we(wr_en), .waddr(s1_col_r), .wdata(s1_ctl_r.level),
    .re(accept), .raddr(raddr_b), .rdata(rd_r)
  );
  idps_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_ram_top (
    .clk(clk), .we(wr_en), .waddr(s1_col_r), .wdata(ctr_eff),
    .re(accept), .raddr(col), .rdata(rd_t)
  );

  // same-column write and read on one edge (one-pixel rows): take the bypass
  assign ctr_eff = fwd_r ? prev_lvl_r : rd_c;
  assign top_eff = fwd_r ? prev_ctr_r : rd_t;

  always_comb begin
    v_c = lvl_value(ctr_eff);
    v_t = lvl_value(top_eff);
    v_b = lvl_value(s1_ctl_r.level);
    v_l = lvl_value(prev_ctr_r);
    v_r = lvl_value(rd_r);
    acc = $signed({2'b00, v_c, 2'b00}) + $signed({4'b0000, v_c})
        - $signed({4'b0000, v_t}) - $signed({4'b0000, v_b})
        - $signed({4'b0000, v_l}) - $signed({4'b0000, v_r});
    if (s1_ctl_r.border) begin
      res = v_c;
    end else if (acc < 12'sd0) begin
      res = VAL_ZERO;
    end else if (acc > 12'sd255) begin
      res = VAL_FULL;
    end else begin
      res = acc[7:0];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    fwd_nxt      = fwd_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      fwd_nxt      = s1_valid_r && s1_ctl_r.wr && (s1_col_r == col);
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      fwd_nxt      = 1'b0;
    end
    out_valid_nxt = out_free ? (s1_valid_r && s1_ctl_r.emit) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= ctl;
      s1_col_r <= col;
    end
    if (wr_en) begin
      prev_lvl_r <= s1_ctl_r.level;
      prev_ctr_r <= ctr_eff;
    end
    if (out_free) begin
      out_pix_r  <= res;
      out_last_r <= s1_ctl_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_last  = out_last_r;

`ifndef SYNTH
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("bypass flagged with empty stage");
  a_interior_col: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ctl_r.emit && !s1_ctl_r.border) |-> (s1_col_r != '0))
    else $error("interior result on column zero");
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ctl_r.emit && out_free) |=> out_valid_r)
    else $error("result lost between stage and output register");
`endif

endmodule

@@ tb/sv/idps_result_checker.sv @@
// Result checker for the diff/posterize/sharpen stream: predicts each pixel and compares it.
`timescale 1ns / 1ps
module idps_result_checker import idps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] pixel_a, [15:8] pixel_b
  input  logic        in_tuser,   // [0] command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] pixel_out
  input  logic        out_tlast,  // frame_last
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatch_count,
  output int          pending_count
);

  localparam int MAX_W       = DEF_MAX_WIDTH;
  localparam int MAX_H       = DEF_MAX_HEIGHT;
  localparam int LEVEL_DEPTH = 2 * MAX_W + 1;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } diff_pixel_t;

  diff_pixel_t expected_pixels[$];
  lvl_t        level_mem [LEVEL_DEPTH];
  logic [7:0]  width_reg;
  logic [7:0]  height_reg;
  int          in_col, in_row, out_col, out_row;
  logic        input_done;

  function automatic int clamp_dim(input logic [7:0] v, input int max_dim);
    if (v == 8'd0) return 1;
    if (int'(v) > max_dim) return max_dim;
    return int'(v);
  endfunction

  function automatic lvl_t quantize(input logic [7:0] a, input logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    if (d < int'(THR_LOW)) return LVL_ZERO;
    if (d < int'(THR_HIGH)) return LVL_MID;
    return LVL_FULL;
  endfunction

  function automatic int level_at(input int row, input int col, input int w);
    lvl_t l;
    l = level_mem[(row * w + col) % LEVEL_DEPTH];
    case (l)
      LVL_ZERO: return int'(VAL_ZERO);
      LVL_MID:  return int'(VAL_MID);
      default:  return int'(VAL_FULL);
    endcase
  endfunction

  function automatic void restart_frame();
    in_col     = 0;
    in_row     = 0;
    out_col    = 0;
    out_row    = 0;
    input_done = 1'b0;
  endfunction

  // Pixel at the output position: border passes its level, interior is sharpened.
  task automatic release_pixel(input int w, input int h);
    diff_pixel_t res;
    int          v;
    res.last = (out_row == h - 1) && (out_col == w - 1);
    if (out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1) begin
      v = level_at(out_row, out_col, w);
    end else begin
      v = 5 * level_at(out_row, out_col, w) - level_at(out_row - 1, out_col, w)
          - level_at(out_row + 1, out_col, w) - level_at(out_row, out_col - 1, w)
          - level_at(out_row, out_col + 1, w);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
    end
    res.pixel = v[7:0];
    expected_pixels.push_back(res);
    if (res.last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic take_item(input logic cmd, input logic [7:0] a, input logic [7:0] b);
    int   w, h;
    logic row_above;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    if (cmd == CMD_DRAIN) begin
      if (input_done) release_pixel(w, h);
    end else if (!input_done) begin
      level_mem[(in_row * w + in_col) % LEVEL_DEPTH] = quantize(a, b);
      row_above = (in_row >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row     = 0;
          input_done = 1'b1;
        end
      end
      if (row_above) release_pixel(w, h);
    end
  endtask

  task automatic note_mismatch(input diff_pixel_t want, input diff_pixel_t got, input bit orphan);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      if (orphan) begin
        $display("%0t: unexpected result pixel=%0d last=%0b", $realtime, got.pixel, got.last);
      end else begin
        $display("%0t: result mismatch: expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
                 $realtime, want.pixel, want.last, got.pixel, got.last);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    diff_pixel_t got;
    diff_pixel_t want;
    if (!rst_n) begin
      width_reg      = 8'(DEF_DIM);
      height_reg     = 8'(DEF_DIM);
      mismatch_count = 0;
      restart_frame();
      expected_pixels.delete();
    end else begin
      // results first: an item taken at this edge cannot have its result out yet
      if (out_tvalid && out_tready) begin
        got.pixel = out_tdata;
        got.last  = out_tlast;
        if (expected_pixels.size() == 0) begin
          note_mismatch(got, got, 1'b1);
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel !== want.pixel || got.last !== want.last) note_mismatch(want, got, 1'b0);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) begin
          width_reg = cfg_data;
          restart_frame();
        end else if (cfg_index == REG_HEIGHT) begin
          height_reg = cfg_data;
          restart_frame();
        end
      end
      if (in_tvalid && in_tready) take_item(in_tuser, in_tdata[7:0], in_tdata[15:8]);
    end
    pending_count = expected_pixels.size();
  end

endmodule

@@ tb/sv/tb_image_diff_posterize_sharpen_top.sv @@
// Testbench top for the diff/posterize/sharpen block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_image_diff_posterize_sharpen_top;
  import idps_pkg::*;

  localparam int TARGET_ITEMS  = 1550;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the pipe
  localparam int DRAIN_WAIT    = 8;     // stage and output registers plus margin
  localparam int SETTLE_CYCLES = 20;
  // ~1800 items with idling in the slow phases, plus the hold-off;
  // the limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT   = 400000;

  // sender / receiver idling schedule
  typedef enum logic [1:0] {
    PACE_RX_SLOW,   // sender idles 30%, receiver 51%
    PACE_TX_SLOW,   // sender idles 51%, receiver 30%
    PACE_FULL       // no idling on either side
  } pace_t;

  // corner pairs {pixel_b, pixel_a} for a 4x3 frame: diffs 0, 31, 32, 95, 96,
  // max and equal values; row 1 column 1 is a dark center between bright
  // left and right neighbors so the sharpen clips low, column 2 clips high
  localparam logic [15:0] EDGE_PAIRS [12] = '{
    {8'd0,   8'd0},   {8'd0,   8'd31},  {8'd32,  8'd0},   {8'd160, 8'd255},
    {8'd96,  8'd0},   {8'd7,   8'd7},   {8'd255, 8'd0},   {8'd104, 8'd200},
    {8'd10,  8'd10},  {8'd255, 8'd255}, {8'd127, 8'd128}, {8'd128, 8'd0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = CMD_PIXEL;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [1:0]  cfg_index  = REG_WIDTH;
  logic [7:0]  cfg_data   = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_ready;
  int          mismatch_count;
  int          pending_count;

  pace_t       pace        = PACE_RX_SLOW;
  logic        hold_go     = 1'b0;  // set once by the stimulus
  logic        hold_done   = 1'b0;  // set by the receiver when the hold-off is over
  int          items_sent  = 0;
  int          cycle_count = 0;
  logic [7:0]  raw_w       = 8'(DEF_DIM);
  logic [7:0]  raw_h       = 8'(DEF_DIM);
  int          frame_w     = DEF_DIM;
  int          frame_h     = DEF_DIM;

  image_diff_posterize_sharpen_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  idps_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // 12 ns period
  always #6 clk = ~clk;

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random back-pressure per pace, plus one long hold-off while the
  // sender keeps offering items so the block fills and drops in_tready.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        case (pace)
          PACE_RX_SLOW: out_tready <= ($urandom_range(99) >= 51);
          PACE_TX_SLOW: out_tready <= ($urandom_range(99) >= 30);
          default:      out_tready <= 1'b1;
        endcase
      end
    end
  end

  function automatic int clamp_dim(input logic [7:0] v, input int max_dim);
    if (v == 8'd0) return 1;
    if (int'(v) > max_dim) return max_dim;
    return int'(v);
  endfunction

  // Half fully random pairs, half aimed at one of the three levels so that
  // zero, mid and full levels all show up often.
  function automatic logic [15:0] random_pair();
    int         d;
    int         a;
    logic [7:0] lo;
    logic [7:0] hi;
    if ($urandom_range(1) == 0) return 16'($urandom);
    case ($urandom_range(2))
      0:       d = $urandom_range(31);
      1:       d = $urandom_range(95, 32);
      default: d = $urandom_range(255, 96);
    endcase
    a  = $urandom_range(255 - d);
    lo = 8'(a);
    hi = 8'(a + d);
    return ($urandom_range(1) == 0) ? {hi, lo} : {lo, hi};
  endfunction

  // Offer one item, idling first per the pace; returns on the negedge after the
  // accepting edge. tvalid is left high so back-to-back items need no toggle.
  task automatic push_item(input logic cmd, input logic [7:0] a, input logic [7:0] b,
                           input bit counted);
    int gap_pct;
    case (pace)
      PACE_RX_SLOW: gap_pct = 30;
      PACE_TX_SLOW: gap_pct = 51;
      default:      gap_pct = 0;
    endcase
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (counted) items_sent++;
    if (items_sent < TARGET_ITEMS / 3) pace = PACE_RX_SLOW;
    else if (items_sent < 2 * TARGET_ITEMS / 3) pace = PACE_TX_SLOW;
    else pace = PACE_FULL;
  endtask

  // Stop offering and wait until every predicted pixel is out, then give the
  // pipeline time to finish items that release nothing.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Register writes only while idle; any write restarts the frame.
  task automatic configure(input bit do_w, input bit do_h, input logic [7:0] w_val,
                           input logic [7:0] h_val);
    settle_block();
    if (do_h && $urandom_range(1) == 0) begin
      write_reg(REG_HEIGHT, h_val);
      raw_h = h_val;
      do_h  = 1'b0;
    end
    if (do_w) begin
      write_reg(REG_WIDTH, w_val);
      raw_w = w_val;
    end
    if (do_h) begin
      write_reg(REG_HEIGHT, h_val);
      raw_h = h_val;
    end
    cfg_valid <= 1'b0;
    frame_w = clamp_dim(raw_w, DEF_MAX_WIDTH);
    frame_h = clamp_dim(raw_h, DEF_MAX_HEIGHT);
  endtask

  // One frame: pixel pairs then drains, with some noise mixed in (drains before
  // the frame is in, pairs after it is in, drains after the frame closed).
  // A broken frame stops partway; the caller restarts it with a register write.
  task automatic run_frame(input bit broken);
    int          n_pix;
    int          k;
    logic [15:0] pair;
    n_pix = frame_w * frame_h;
    if (broken) n_pix = $urandom_range(n_pix - 1);
    if (pace == PACE_FULL && !hold_go && frame_h >= 2) hold_go = 1'b1;
    if ($urandom_range(99) < 15) begin
      push_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 1'b0);
    end
    for (k = 0; k < n_pix; k++) begin
      if ($urandom_range(99) < 3) begin
        push_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 1'b0);
      end
      pair = random_pair();
      push_item(CMD_PIXEL, pair[7:0], pair[15:8], 1'b1);
    end
    if (!broken) begin
      for (k = 0; k < frame_w; k++) begin
        if ($urandom_range(99) < 5) begin
          pair = random_pair();
          push_item(CMD_PIXEL, pair[7:0], pair[15:8], 1'b0);
        end
        push_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 1'b1);
      end
      if ($urandom_range(99) < 15) begin
        push_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int   k;
    int   f;
    int   frames;
    int   which;
    bit   broken;
    logic [7:0] w_val;
    logic [7:0] h_val;

    // hold reset, then release it
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed 4x3 frame: early drain, corner pairs, a pair after the frame is
    // in, the four drains of the last row, then a drain with nothing pending
    configure(1'b1, 1'b1, 8'd4, 8'd3);
    push_item(CMD_DRAIN, 8'hff, 8'hff, 1'b0);
    for (k = 0; k < 12; k++) begin
      push_item(CMD_PIXEL, EDGE_PAIRS[k][7:0], EDGE_PAIRS[k][15:8], 1'b1);
    end
    push_item(CMD_PIXEL, 8'd255, 8'd0, 1'b0);
    for (k = 0; k < 4; k++) push_item(CMD_DRAIN, 8'h00, 8'hff, 1'b1);
    push_item(CMD_DRAIN, 8'h00, 8'h00, 1'b0);

    // size extremes: zero dims act as 1, oversized ones clamp to the maximum;
    // full width with three rows reaches the far end of the line buffers
    configure(1'b1, 1'b1, 8'd0, 8'd0);
    run_frame(1'b0);
    run_frame(1'b0);
    configure(1'b1, 1'b1, 8'd255, 8'd3);
    run_frame(1'b0);
    configure(1'b1, 1'b1, 8'd0, 8'd255);
    run_frame(1'b0);

    // random small frames until the item budget is used
    while (items_sent < TARGET_ITEMS) begin
      w_val = 8'($urandom_range(12, 1));
      h_val = 8'($urandom_range(8, 1));
      which = $urandom_range(3);
      configure(which != 2, which != 1, w_val, h_val);
      frames = $urandom_range(3, 1);
      for (f = 0; f < frames; f++) begin
        broken = ($urandom_range(99) < 12);
        run_frame(broken);
        // restart the cut frame by rewriting one register with its value
        if (broken) begin
          if ($urandom_range(1) == 0) configure(1'b1, 1'b0, raw_w, raw_h);
          else configure(1'b0, 1'b1, raw_w, raw_h);
        end
      end
    end

    settle_block();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/idps_pkg.sv
rtl/idps_ram.sv
rtl/idps_ctrl.sv
rtl/idps_filter.sv
rtl/image_diff_posterize_sharpen_top.sv
tb/sv/idps_result_checker.sv
tb/sv/tb_image_diff_posterize_sharpen_top.sv
